>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define MCR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen out of reset.
`define MCR_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/mcr_pkg.sv
// Shared types and constants of the midpoint circle rasterizer.
package mcr_pkg;

	localparam int COORD_BITS   = 11;
	localparam int STEP_BITS    = 11;
	localparam int DEC_BITS     = 16;
	localparam int RADIUS_BITS  = 10;
	localparam int FRAME_BITS   = 10;
	localparam int COLOR_BITS   = 16;
	localparam int ADDR_BITS    = 20;
	localparam int PT_BITS      = (COORD_BITS > STEP_BITS ? COORD_BITS : STEP_BITS) + 1;
	localparam int PTS_PER_STEP = 8;
	localparam int PT_IDX_BITS  = $clog2(PTS_PER_STEP);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic FUNC_START   = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FRAME_BITS-1:0] FRAME_RESET = FRAME_BITS'(360);

	localparam logic signed [DEC_BITS-1:0] DEC_INIT     = DEC_BITS'(3);
	localparam logic signed [DEC_BITS-1:0] DEC_INC_EAST = DEC_BITS'(6);
	localparam logic signed [DEC_BITS-1:0] DEC_INC_DIAG = DEC_BITS'(10);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [STEP_BITS-1:0]  x;
		logic signed [STEP_BITS-1:0]  y;
		logic [COLOR_BITS-1:0]        color;
		logic                         done;
		logic                         idle;
	} step_rec_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} queue_status_t;

endpackage

>>> src/mcr_front.sv
// Front end: accepts items, runs the arc walk and produces one step record per item.
module mcr_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic                                 func,
	input  logic signed [mcr_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [mcr_pkg::COORD_BITS-1:0] center_y,
	input  logic [mcr_pkg::RADIUS_BITS-1:0]      radius,
	input  logic [mcr_pkg::COLOR_BITS-1:0]       pixel_color,
	output mcr_pkg::step_rec_t                   rec
);

	logic signed [mcr_pkg::COORD_BITS-1:0] ctr_x_q, ctr_y_q;
	logic [mcr_pkg::COLOR_BITS-1:0]        color_q;
	logic signed [mcr_pkg::STEP_BITS-1:0]  step_x_q, step_y_q;
	logic signed [mcr_pkg::DEC_BITS-1:0]   dec_q;
	logic                                  active_q;

	logic                                  start;
	logic                                  idle;
	logic signed [mcr_pkg::STEP_BITS-1:0]  cur_x, cur_y, nxt_x, nxt_y;
	logic signed [mcr_pkg::DEC_BITS-1:0]   cur_d, nxt_d, x16, y16;
	logic                                  done;

	assign start = (func == mcr_pkg::FUNC_START);
	assign idle  = (func == mcr_pkg::FUNC_ADVANCE) && !active_q;

	always_comb begin
		if (start) begin
			cur_x = '0;
			cur_y = mcr_pkg::STEP_BITS'(radius);
			cur_d = mcr_pkg::DEC_INIT - mcr_pkg::DEC_BITS'({radius, 1'b0});
		end else begin
			cur_x = step_x_q;
			cur_y = step_y_q;
			cur_d = dec_q;
		end
		x16 = mcr_pkg::DEC_BITS'(cur_x);
		y16 = mcr_pkg::DEC_BITS'(cur_y);
		nxt_x = cur_x + mcr_pkg::STEP_BITS'(1);
		if (cur_d[mcr_pkg::DEC_BITS-1]) begin
			nxt_d = cur_d + (x16 <<< 2) + mcr_pkg::DEC_INC_EAST;
			nxt_y = cur_y;
		end else begin
			nxt_d = cur_d + ((x16 - y16) <<< 2) + mcr_pkg::DEC_INC_DIAG;
			nxt_y = cur_y - mcr_pkg::STEP_BITS'(1);
		end
		done = (nxt_x > nxt_y);
	end

	always_comb begin
		rec.cx    = start ? center_x : ctr_x_q;
		rec.cy    = start ? center_y : ctr_y_q;
		rec.x     = cur_x;
		rec.y     = cur_y;
		rec.color = idle ? '0 : (start ? pixel_color : color_q);
		rec.done  = idle ? 1'b1 : done;
		rec.idle  = idle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x_q  <= '0;
			ctr_y_q  <= '0;
			color_q  <= '0;
			step_x_q <= '0;
			step_y_q <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else if (accept && !idle) begin
			if (start) begin
				ctr_x_q <= center_x;
				ctr_y_q <= center_y;
				color_q <= pixel_color;
			end
			step_x_q <= nxt_x;
			step_y_q <= nxt_y;
			dec_q    <= nxt_d;
			active_q <= !done;
		end
	end

endmodule

>>> src/mcr_queue.sv
// Short register queue of step records between front and back end.
module mcr_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mcr_pkg::step_rec_t     push_rec,
	input  logic                   pop,
	output mcr_pkg::step_rec_t     head_rec,
	output mcr_pkg::queue_status_t status
);

	mcr_pkg::step_rec_t                 entry_q [mcr_pkg::QUEUE_DEPTH];
	logic [mcr_pkg::QPTR_BITS-1:0]      wr_ptr_q, rd_ptr_q;
	logic [mcr_pkg::QCNT_BITS-1:0]      count_q;

	localparam logic [mcr_pkg::QPTR_BITS-1:0] LAST_PTR =
		mcr_pkg::QPTR_BITS'(mcr_pkg::QUEUE_DEPTH - 1);

	assign head_rec        = entry_q[rd_ptr_q];
	assign status.full     = (count_q == mcr_pkg::QCNT_BITS'(mcr_pkg::QUEUE_DEPTH));
	assign status.nonempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + mcr_pkg::QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + mcr_pkg::QPTR_BITS'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + mcr_pkg::QCNT_BITS'(1);
				2'b01:   count_q <= count_q - mcr_pkg::QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/mcr_back.sv
// Back end: expands each step record into eight clipped, addressed pixels.
module mcr_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mcr_pkg::step_rec_t                head_rec,
	input  mcr_pkg::queue_status_t            status,
	output logic                              pop,
	input  logic [mcr_pkg::FRAME_BITS-1:0]    frame_width,
	input  logic [mcr_pkg::FRAME_BITS-1:0]    frame_height,
	output logic                              pix_valid,
	input  logic                              pix_stall,
	output logic [mcr_pkg::FRAME_BITS-1:0]    pixel_x,
	output logic [mcr_pkg::FRAME_BITS-1:0]    pixel_y,
	output logic [mcr_pkg::COLOR_BITS-1:0]    color_out,
	output logic [mcr_pkg::ADDR_BITS-1:0]     pixel_address,
	output logic                              in_frame,
	output logic                              last_of_step,
	output logic                              circle_done
);

	logic [mcr_pkg::PT_IDX_BITS-1:0] k_q;
	logic                            en, issue, last;
	logic signed [mcr_pkg::PT_BITS-1:0] cx, cy, off_a, off_b, px, py;
	logic                            on_frame;

	logic                            vld_s1;
	logic [mcr_pkg::FRAME_BITS-1:0]  px_s1, py_s1;
	logic [mcr_pkg::COLOR_BITS-1:0]  color_s1;
	logic                            in_s1, last_s1, done_s1;

	logic                            vld_s2;
	logic [mcr_pkg::FRAME_BITS-1:0]  px_s2, py_s2;
	logic [mcr_pkg::COLOR_BITS-1:0]  color_s2;
	logic [mcr_pkg::ADDR_BITS-1:0]   addr_s2;
	logic                            in_s2, last_s2, done_s2;

	assign en    = !vld_s2 || !pix_stall;
	assign issue = en && status.nonempty;
	assign last  = (k_q == mcr_pkg::PT_IDX_BITS'(mcr_pkg::PTS_PER_STEP - 1));
	assign pop   = issue && last;

	always_comb begin
		cx    = mcr_pkg::PT_BITS'(head_rec.cx);
		cy    = mcr_pkg::PT_BITS'(head_rec.cy);
		off_a = k_q[2] ? mcr_pkg::PT_BITS'(head_rec.y) : mcr_pkg::PT_BITS'(head_rec.x);
		off_b = k_q[2] ? mcr_pkg::PT_BITS'(head_rec.x) : mcr_pkg::PT_BITS'(head_rec.y);
		px    = k_q[0] ? cx - off_a : cx + off_a;
		py    = k_q[1] ? cy - off_b : cy + off_b;
		on_frame = !head_rec.idle && !px[mcr_pkg::PT_BITS-1] && !py[mcr_pkg::PT_BITS-1]
			&& ($unsigned(px) < mcr_pkg::PT_BITS'(frame_width))
			&& ($unsigned(py) < mcr_pkg::PT_BITS'(frame_height));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			if (issue) begin
				k_q <= k_q + mcr_pkg::PT_IDX_BITS'(1);
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1    <= on_frame ? px[mcr_pkg::FRAME_BITS-1:0] : '0;
			py_s1    <= on_frame ? py[mcr_pkg::FRAME_BITS-1:0] : '0;
			color_s1 <= head_rec.color;
			in_s1    <= on_frame;
			last_s1  <= last;
			done_s1  <= head_rec.done;

			px_s2    <= px_s1;
			py_s2    <= py_s1;
			color_s2 <= color_s1;
			addr_s2  <= mcr_pkg::ADDR_BITS'(py_s1) * mcr_pkg::ADDR_BITS'(frame_width)
				+ mcr_pkg::ADDR_BITS'(px_s1);
			in_s2    <= in_s1;
			last_s2  <= last_s1;
			done_s2  <= done_s1;
		end
	end

	assign pix_valid     = vld_s2;
	assign pixel_x       = px_s2;
	assign pixel_y       = py_s2;
	assign color_out     = color_s2;
	assign pixel_address = addr_s2;
	assign in_frame      = in_s2;
	assign last_of_step  = last_s2;
	assign circle_done   = done_s2;

endmodule

>>> src/midpoint_circle_rasterizer_top.sv
// Top level of the midpoint circle rasterizer.
// Item channel (item_valid / item_stall): func 0 starts a circle from center_x,
// center_y, radius and pixel_color; func 1 advances the walk one arc step.
// Every transaction on the item channel yields exactly eight transactions on
// the pixel channel (pix_valid / pix_stall), one octant point each, with the
// eighth marked last_of_step and all eight carrying circle_done for that step.
// Points outside the frame come out with in_frame low and zero coordinates and
// address; an advance with no circle running gives eight such points, done set.
// Frame size is written on the cfg port (index 0 width, 1 height); the user
// must do so only while idle, as the block does not enforce it. Throughput:
// one point per cycle while pixels are not stalled, set by the point sequencer
// of the back end; the front end computes each arc step combinationally, and
// a two-entry step queue lets it take items while points are still draining.
// Reset: no circle running, frame 360 by 360, queue and pipeline empty.
// A stalled pixel holds, the back end freezes, and once the queue is full
// item_stall rises until the back end frees an entry.
module midpoint_circle_rasterizer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [mcr_pkg::FRAME_BITS-1:0]        cfg_data,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  func,
	input  logic signed [mcr_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [mcr_pkg::COORD_BITS-1:0] center_y,
	input  logic [mcr_pkg::RADIUS_BITS-1:0]       radius,
	input  logic [mcr_pkg::COLOR_BITS-1:0]        pixel_color,
	output logic                                  pix_valid,
	input  logic                                  pix_stall,
	output logic [mcr_pkg::FRAME_BITS-1:0]        pixel_x,
	output logic [mcr_pkg::FRAME_BITS-1:0]        pixel_y,
	output logic [mcr_pkg::COLOR_BITS-1:0]        color_out,
	output logic [mcr_pkg::ADDR_BITS-1:0]         pixel_address,
	output logic                                  in_frame,
	output logic                                  last_of_step,
	output logic                                  circle_done
);

	logic [mcr_pkg::FRAME_BITS-1:0] frame_width_q, frame_height_q;
	logic                           accept, pop;
	mcr_pkg::step_rec_t             front_rec, head_rec;
	mcr_pkg::queue_status_t         status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= mcr_pkg::FRAME_RESET;
			frame_height_q <= mcr_pkg::FRAME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				mcr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default:                   frame_width_q  <= frame_width_q;
			endcase
		end
	end

	assign item_stall = status.full;
	assign accept     = item_valid && !status.full;

	mcr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.func        (func),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.pixel_color (pixel_color),
		.rec         (front_rec)
	);

	mcr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_rec (front_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.status   (status)
	);

	mcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_rec      (head_rec),
		.status        (status),
		.pop           (pop),
		.frame_width   (frame_width_q),
		.frame_height  (frame_height_q),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.color_out     (color_out),
		.pixel_address (pixel_address),
		.in_frame      (in_frame),
		.last_of_step  (last_of_step),
		.circle_done   (circle_done)
	);

endmodule

>>> src/mcr_checker.sv
// Port-level checker for the midpoint circle rasterizer, bound to the top level.
`include "assert_macros.svh"

module mcr_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  pix_valid,
	input logic                                  pix_stall,
	input logic [mcr_pkg::FRAME_BITS-1:0]        pixel_x,
	input logic [mcr_pkg::FRAME_BITS-1:0]        pixel_y,
	input logic [mcr_pkg::ADDR_BITS-1:0]         pixel_address,
	input logic                                  in_frame,
	input logic                                  last_of_step,
	input logic                                  circle_done
);

	logic [mcr_pkg::PT_IDX_BITS-1:0] pt_cnt_q;
	logic                            done_q;
	logic                            pix_xfer;

	assign pix_xfer = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_cnt_q <= '0;
			done_q   <= 1'b0;
		end else if (pix_xfer) begin
			pt_cnt_q <= pt_cnt_q + mcr_pkg::PT_IDX_BITS'(1);
			if (pt_cnt_q == '0) begin
				done_q <= circle_done;
			end
		end
	end

	`MCR_ASSERT(a_stall_hold, clk, arst_n, pix_valid && pix_stall |=> pix_valid && $stable(pixel_address) && $stable(last_of_step), "stalled pixel changed")
	`MCR_ASSERT(a_last_mark, clk, arst_n, pix_valid |-> (last_of_step == (pt_cnt_q == mcr_pkg::PT_IDX_BITS'(mcr_pkg::PTS_PER_STEP - 1))), "last_of_step out of place")
	`MCR_ASSERT(a_done_steady, clk, arst_n, pix_valid && (pt_cnt_q != '0) |-> (circle_done == done_q), "circle_done changed within a step")
	`MCR_NEVER(a_clip_zero, clk, arst_n, pix_valid && !in_frame && ((pixel_x != '0) || (pixel_y != '0) || (pixel_address != '0)), "out-of-frame point not zeroed")

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (.*);
